FILE: hdl/poe_pkg.sv
// poe_pkg: shared types, constants and helpers for the polyline offset edges core
// no dependencies; imported by every module under hdl

package poe_pkg;

    localparam int COORD_BITS   = 32;
    localparam int MAX_VERTICES = 65536;
    localparam int CNT_W        = 17;
    localparam int IDX_W        = 16;
    localparam int LW_W         = 31;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_CLOSED_MODE = cfg_idx_t'(0);
    localparam cfg_idx_t REG_LINE_WIDTH  = cfg_idx_t'(1);

    // saturation bounds for a signed coordinate
    localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
    localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic signed [COORD_BITS-1:0] vertex_z;
        logic                         last_vertex;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]             vertex_index;
        logic signed [COORD_BITS-1:0] left_x;
        logic signed [COORD_BITS-1:0] left_y;
        logic signed [COORD_BITS-1:0] right_x;
        logic signed [COORD_BITS-1:0] right_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic                         run_last;
    } out_item_t;

    // unit vector, signed Q2.30 per component
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } nrm_t;

    typedef enum logic [1:0] {
        EK_PEND,
        EK_NEWOPEN,
        EK_NEWCLS,
        EK_START
    } emit_kind_t;

    typedef enum logic [1:0] {
        NS_SEG,
        NS_CLS,
        NS_VN
    } norm_src_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_CHECK,
        CS_SEG_W,
        CS_CLS,
        CS_CLS_W,
        CS_VN,
        CS_VN_W,
        CS_MUL,
        CS_OUT,
        CS_ADV
    } ctrl_state_t;

    typedef enum logic [2:0] {
        NM_IDLE,
        NM_SHIFT,
        NM_SQ,
        NM_SUM,
        NM_SQRT,
        NM_DIVI,
        NM_DIV,
        NM_DONE
    } norm_state_t;

    typedef struct packed {
        logic       ld_in;
        logic       first;
        logic       norm_go;
        norm_src_t  norm_src;
        logic       ld_seg;
        logic       ld_cls;
        logic       ld_vn;
        logic       ld_mul;
        logic       ld_out;
        logic       out_last;
        emit_kind_t kind;
        logic       advance;
    } poe_cmd_t;

    typedef struct packed {
        logic norm_done;
        logic cnt_zero;
        logic cnt_one;
        logic last_in;
        logic out_free;
    } poe_sts_t;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [34:0] v);
        logic signed [COORD_BITS-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[COORD_BITS-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/polyline_offset_edges_core.sv
// polyline_offset_edges_core: top level, configuration registers and controller/datapath pair
// depends on poe_pkg, poe_ctrl, poe_datapath (and poe_norm below it)

// Strokes a polyline: vertices (Q16.16 x, y, z and a last flag) come in as input
// transactions, and for each vertex a left and a right edge point leave, offset by half of
// line_width to the left and right along the vertex normal, saturated to 32 bits.
// A vertex is given out once its successor is known, so results trail the input
// by one vertex; in closed mode vertex 0 comes out last, after the final vertex.
// A polyline of one vertex gives nothing. run_last marks the last result of an
// input transaction. One vertex is worked at a time: s_ready is high only while
// the sequencer is idle. All normal math runs through one shared iterative
// normalizer (prescale shifts, a square step, a sum step, a 32-step bit-serial
// root, a divider load step, a 31-step divide for both components and a done
// step); a zero vector goes straight to done. The first vertex is only stored;
// a middle vertex takes one segment and one vertex normalization (in closed mode
// vertex 1 takes only the segment one); the last vertex adds one more
// normalization (open) or three normalizations (closed). An output register
// decouples the result side; the sequencer stalls only when a new result is
// ready and the previous one has not been taken.
// Configuration: index 0 closed_mode (bit 0), index 1 line_width (bits 30:0);
// write only while the core is idle. cfg_ready is always high.

module polyline_offset_edges_core
    import poe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // vertex input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    // edge point output
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic            closed_mode_reg;
    logic [LW_W-1:0] line_width_reg;
    poe_cmd_t        cmd;
    poe_sts_t        sts;

    // config registers never back-pressure
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closed_mode_reg <= 1'b0;
            line_width_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CLOSED_MODE: closed_mode_reg <= cfg_data[0];
                REG_LINE_WIDTH:  line_width_reg  <= cfg_data[LW_W-1:0];
                default: begin
                    // unmapped index: transaction completes, nothing changes
                end
            endcase
        end
    end

    // sequencer: accepts a vertex, steps the normalizer and emissions
    poe_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .closed_mode (closed_mode_reg),
        .sts         (sts),
        .cmd         (cmd)
    );

    // vertex state, normalizer, offset math and output register
    poe_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_data     (s_data),
        .line_width (line_width_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: hdl/poe_norm.sv
// poe_norm: iterative vector normalizer (prescale, square, bit-serial root, two dividers)
// depends on poe_pkg

module poe_norm
    import poe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               go,
    input  logic signed [32:0] in_x,
    input  logic signed [32:0] in_y,
    output logic               done,
    output nrm_t               unit
);

    norm_state_t state_reg, state_next;

    logic        sx_reg, sy_reg;
    logic [32:0] ax_reg, ay_reg;
    logic [61:0] sqx_reg, sqy_reg;
    logic [63:0] v_reg, r_reg, bit_reg;
    logic [4:0]  cnt_reg;
    logic [30:0] lox_reg, loy_reg;
    logic [31:0] remx_reg, remy_reg;
    logic [30:0] qx_reg, qy_reg;

    logic [32:0] mx;
    logic [63:0] t;
    logic        ge;
    logic [61:0] numx, numy;
    logic [32:0] tx, ty, dx, dy;
    logic        gex, gey;

    always_comb begin
        mx   = (ax_reg > ay_reg) ? ax_reg : ay_reg;
        t    = r_reg + bit_reg;
        ge   = v_reg >= t;
        numx = {1'b0, ax_reg[30:0], 30'b0} + {31'b0, r_reg[31:1]};
        numy = {1'b0, ay_reg[30:0], 30'b0} + {31'b0, r_reg[31:1]};
        tx   = {remx_reg, lox_reg[30]};
        ty   = {remy_reg, loy_reg[30]};
        dx   = tx - {1'b0, r_reg[31:0]};
        dy   = ty - {1'b0, r_reg[31:0]};
        gex  = tx >= {1'b0, r_reg[31:0]};
        gey  = ty >= {1'b0, r_reg[31:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        done       = 1'b0;
        case (state_reg)
            NM_IDLE: begin
                if (go) begin
                    state_next = (in_x == '0 && in_y == '0) ? NM_DONE : NM_SHIFT;
                end
            end
            NM_SHIFT: begin
                if (mx[32:31] == 2'b00 && mx[30]) begin
                    state_next = NM_SQ;
                end
            end
            NM_SQ:   state_next = NM_SUM;
            NM_SUM:  state_next = NM_SQRT;
            NM_SQRT: begin
                if (cnt_reg == '0) begin
                    state_next = NM_DIVI;
                end
            end
            NM_DIVI: state_next = NM_DIV;
            NM_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = NM_DONE;
                end
            end
            NM_DONE: begin
                done       = 1'b1;
                state_next = NM_IDLE;
            end
            default: state_next = NM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            NM_IDLE: begin
                if (go) begin
                    sx_reg <= in_x[32];
                    sy_reg <= in_y[32];
                    ax_reg <= in_x[32] ? 33'(-in_x) : 33'(in_x);
                    ay_reg <= in_y[32] ? 33'(-in_y) : 33'(in_y);
                    qx_reg <= '0;
                    qy_reg <= '0;
                end
            end
            NM_SHIFT: begin
                if (mx[32:31] != 2'b00) begin
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                end else if (!mx[30]) begin
                    ax_reg <= ax_reg << 1;
                    ay_reg <= ay_reg << 1;
                end
            end
            NM_SQ: begin
                sqx_reg <= ax_reg[30:0] * ax_reg[30:0];
                sqy_reg <= ay_reg[30:0] * ay_reg[30:0];
            end
            NM_SUM: begin
                v_reg   <= {2'b0, sqx_reg} + {2'b0, sqy_reg};
                r_reg   <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
                cnt_reg <= 5'd31;
            end
            NM_SQRT: begin
                if (ge) begin
                    v_reg <= v_reg - t;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - 5'd1;
            end
            NM_DIVI: begin
                remx_reg <= {1'b0, numx[61:31]};
                remy_reg <= {1'b0, numy[61:31]};
                lox_reg  <= numx[30:0];
                loy_reg  <= numy[30:0];
                qx_reg   <= '0;
                qy_reg   <= '0;
                cnt_reg  <= 5'd30;
            end
            NM_DIV: begin
                remx_reg <= gex ? dx[31:0] : tx[31:0];
                remy_reg <= gey ? dy[31:0] : ty[31:0];
                qx_reg   <= {qx_reg[29:0], gex};
                qy_reg   <= {qy_reg[29:0], gey};
                lox_reg  <= lox_reg << 1;
                loy_reg  <= loy_reg << 1;
                cnt_reg  <= cnt_reg - 5'd1;
            end
            default: begin
            end
        endcase
    end

    assign unit.x = sx_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
    assign unit.y = sy_reg ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg});

endmodule

FILE: hdl/poe_datapath.sv
// poe_datapath: vertex and normal registers, operand muxes, offset multipliers, output register
// depends on poe_pkg and poe_norm

module poe_datapath
    import poe_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  poe_cmd_t        cmd,
    output poe_sts_t        sts,
    input  in_item_t        s_data,
    input  logic [LW_W-1:0] line_width,
    output logic            m_valid,
    input  logic            m_ready,
    output out_item_t       m_data
);

    logic signed [31:0] in_x_reg, in_y_reg, in_z_reg;
    logic               last_reg;
    logic signed [31:0] pend_x_reg, pend_y_reg, pend_z_reg;
    logic signed [31:0] start_x_reg, start_y_reg, start_z_reg;
    logic [CNT_W-1:0]   count_reg;
    nrm_t               inc_reg, ssn_reg, seg_reg, cls_reg, vn_reg;
    logic [62:0]        prodx_reg, prody_reg;
    logic               negx_reg, negy_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic               norm_done;
    nrm_t               unit, rot;
    logic signed [32:0] op_x, op_y, sum_x, sum_y;
    nrm_t               na, nb;
    logic signed [31:0] vx, vy, vz;
    logic [CNT_W-1:0]   vidx;
    logic [31:0]        magx, magy;
    logic [63:0]        rndx, rndy;
    logic signed [33:0] ofx, ofy;
    logic signed [34:0] ex, ey;

    poe_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (cmd.norm_go),
        .in_x    (op_x),
        .in_y    (op_y),
        .done    (norm_done),
        .unit    (unit)
    );

    // left normal of a segment direction
    assign rot.x = -unit.y;
    assign rot.y = unit.x;

    always_comb begin
        case (cmd.kind)
            EK_PEND: begin
                na   = (count_reg == CNT_W'(1)) ? '0 : inc_reg;
                nb   = seg_reg;
                vx   = pend_x_reg;
                vy   = pend_y_reg;
                vz   = pend_z_reg;
                vidx = count_reg - CNT_W'(1);
            end
            EK_NEWOPEN: begin
                na   = seg_reg;
                nb   = '0;
                vx   = in_x_reg;
                vy   = in_y_reg;
                vz   = in_z_reg;
                vidx = count_reg;
            end
            EK_NEWCLS: begin
                na   = seg_reg;
                nb   = cls_reg;
                vx   = in_x_reg;
                vy   = in_y_reg;
                vz   = in_z_reg;
                vidx = count_reg;
            end
            default: begin
                na   = cls_reg;
                nb   = ssn_reg;
                vx   = start_x_reg;
                vy   = start_y_reg;
                vz   = start_z_reg;
                vidx = '0;
            end
        endcase

        sum_x = 33'(na.x) + 33'(nb.x);
        sum_y = 33'(na.y) + 33'(nb.y);

        case (cmd.norm_src)
            NS_SEG: begin
                op_x = 33'(in_x_reg) - 33'(pend_x_reg);
                op_y = 33'(in_y_reg) - 33'(pend_y_reg);
            end
            NS_CLS: begin
                op_x = 33'(start_x_reg) - 33'(in_x_reg);
                op_y = 33'(start_y_reg) - 33'(in_y_reg);
            end
            default: begin
                // opposite normals cancel: fall back to the second one
                if (sum_x == '0 && sum_y == '0) begin
                    op_x = 33'(nb.x);
                    op_y = 33'(nb.y);
                end else begin
                    op_x = sum_x;
                    op_y = sum_y;
                end
            end
        endcase

        magx = vn_reg.x[31] ? 32'(-vn_reg.x) : 32'(vn_reg.x);
        magy = vn_reg.y[31] ? 32'(-vn_reg.y) : 32'(vn_reg.y);
        rndx = {1'b0, prodx_reg} + 64'h4000_0000;
        rndy = {1'b0, prody_reg} + 64'h4000_0000;
        ofx  = negx_reg ? -$signed({1'b0, rndx[63:31]}) : $signed({1'b0, rndx[63:31]});
        ofy  = negy_reg ? -$signed({1'b0, rndy[63:31]}) : $signed({1'b0, rndy[63:31]});
        ex   = 35'(vx);
        ey   = 35'(vy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.first) begin
                count_reg <= last_reg ? CNT_W'(0) : CNT_W'(1);
            end else if (cmd.advance) begin
                count_reg <= last_reg ? CNT_W'(0) : count_reg + CNT_W'(1);
            end
            if (cmd.ld_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            in_x_reg <= s_data.vertex_x;
            in_y_reg <= s_data.vertex_y;
            in_z_reg <= s_data.vertex_z;
            last_reg <= s_data.last_vertex || (count_reg >= CNT_W'(MAX_VERTICES - 1));
        end
        if (cmd.first) begin
            start_x_reg <= in_x_reg;
            start_y_reg <= in_y_reg;
            start_z_reg <= in_z_reg;
            pend_x_reg  <= in_x_reg;
            pend_y_reg  <= in_y_reg;
            pend_z_reg  <= in_z_reg;
        end
        if (cmd.advance && !last_reg) begin
            pend_x_reg <= in_x_reg;
            pend_y_reg <= in_y_reg;
            pend_z_reg <= in_z_reg;
            inc_reg    <= seg_reg;
        end
        if (cmd.ld_seg) begin
            seg_reg <= rot;
            if (count_reg == CNT_W'(1)) begin
                ssn_reg <= rot;
            end
        end
        if (cmd.ld_cls) begin
            cls_reg <= rot;
        end
        if (cmd.ld_vn) begin
            vn_reg <= unit;
        end
        if (cmd.ld_mul) begin
            prodx_reg <= magx * line_width;
            prody_reg <= magy * line_width;
            negx_reg  <= vn_reg.x[31];
            negy_reg  <= vn_reg.y[31];
        end
        if (cmd.ld_out) begin
            out_reg.vertex_index <= vidx[IDX_W-1:0];
            out_reg.left_x       <= sat_coord(ex + 35'(ofx));
            out_reg.left_y       <= sat_coord(ey + 35'(ofy));
            out_reg.right_x      <= sat_coord(ex - 35'(ofx));
            out_reg.right_y      <= sat_coord(ey - 35'(ofy));
            out_reg.point_z      <= vz;
            out_reg.run_last     <= cmd.out_last;
        end
    end

    assign sts.norm_done = norm_done;
    assign sts.cnt_zero  = (count_reg == '0);
    assign sts.cnt_one   = (count_reg == CNT_W'(1));
    assign sts.last_in   = last_reg;
    assign sts.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: hdl/poe_ctrl.sv
// poe_ctrl: sequencer that walks one vertex through its normalizations and emissions
// depends on poe_pkg

module poe_ctrl
    import poe_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     closed_mode,
    input  poe_sts_t sts,
    output poe_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    emit_kind_t  kind_reg, kind_next;
    logic        closed_reg, closed_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= CS_IDLE;
            kind_reg   <= EK_PEND;
            closed_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            closed_reg <= closed_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        closed_next = closed_reg;
        cmd         = '0;
        cmd.kind    = kind_reg;
        cmd.norm_src = NS_VN;
        s_ready     = (state_reg == CS_IDLE);
        case (state_reg)
            CS_IDLE: begin
                if (s_valid) begin
                    cmd.ld_in   = 1'b1;
                    closed_next = closed_mode;
                    state_next  = CS_CHECK;
                end
            end
            CS_CHECK: begin
                if (sts.cnt_zero) begin
                    cmd.first  = 1'b1;
                    state_next = CS_IDLE;
                end else begin
                    cmd.norm_go  = 1'b1;
                    cmd.norm_src = NS_SEG;
                    state_next   = CS_SEG_W;
                end
            end
            CS_SEG_W: begin
                if (sts.norm_done) begin
                    cmd.ld_seg = 1'b1;
                    if (!(sts.cnt_one && closed_reg)) begin
                        kind_next  = EK_PEND;
                        state_next = CS_VN;
                    end else if (!sts.last_in) begin
                        state_next = CS_ADV;
                    end else begin
                        state_next = CS_CLS;
                    end
                end
            end
            CS_CLS: begin
                cmd.norm_go  = 1'b1;
                cmd.norm_src = NS_CLS;
                state_next   = CS_CLS_W;
            end
            CS_CLS_W: begin
                if (sts.norm_done) begin
                    cmd.ld_cls = 1'b1;
                    kind_next  = EK_NEWCLS;
                    state_next = CS_VN;
                end
            end
            CS_VN: begin
                cmd.norm_go = 1'b1;
                state_next  = CS_VN_W;
            end
            CS_VN_W: begin
                if (sts.norm_done) begin
                    cmd.ld_vn  = 1'b1;
                    state_next = CS_MUL;
                end
            end
            CS_MUL: begin
                cmd.ld_mul = 1'b1;
                state_next = CS_OUT;
            end
            CS_OUT: begin
                if (sts.out_free) begin
                    cmd.ld_out   = 1'b1;
                    cmd.out_last = (kind_reg == EK_PEND) ? !sts.last_in :
                                   (kind_reg == EK_NEWOPEN || kind_reg == EK_START);
                    case (kind_reg)
                        EK_PEND: begin
                            if (!sts.last_in) begin
                                state_next = CS_ADV;
                            end else if (closed_reg) begin
                                state_next = CS_CLS;
                            end else begin
                                kind_next  = EK_NEWOPEN;
                                state_next = CS_VN;
                            end
                        end
                        EK_NEWCLS: begin
                            kind_next  = EK_START;
                            state_next = CS_VN;
                        end
                        default: state_next = CS_ADV;
                    endcase
                end
            end
            CS_ADV: begin
                cmd.advance = 1'b1;
                state_next  = CS_IDLE;
            end
            default: state_next = CS_IDLE;
        endcase
    end

endmodule
